@@ hw/rtl/nearest_palette_colour_assert.svh @@
// Assertion macros for the nearest palette colour checker
`ifndef NEAREST_PALETTE_COLOUR_ASSERT_SVH
`define NEAREST_PALETTE_COLOUR_ASSERT_SVH

// General form: property checked on the rising edge, masked while dis is high
`define NPC_ASSERT(label, clk, dis, prop, msg) \
    label: assert property (@(posedge clk) disable iff (dis) prop) else $error(msg);

// Same, masked while the active-low reset is asserted
`define NPC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    `NPC_ASSERT(label, clk, !(rst_n), prop, msg)

`endif

@@ hw/rtl/npc_pkg.sv @@
// Package for the nearest palette colour block: widths, register codes, distance helpers
package npc_pkg;

    localparam int MAX_SLOTS   = 16;
    localparam int SLOT_W      = 4;
    localparam int COLOUR_W    = 6;
    localparam int LEVEL_W     = 2;
    localparam int WEIGHT_W    = 4;
    localparam int HALF_W      = 48;
    localparam int HALF_SLOTS  = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = HALF_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int SQ_W        = 4;
    localparam int PROD_W      = SQ_W + WEIGHT_W;
    localparam int SUM_W       = PROD_W + 2;
    // largest real distance is 15*9*3 = 405, so nine bits hold it
    localparam int DIST_W      = 9;

    localparam logic [DIST_W-1:0]   DIST_MAX      = '1;
    localparam logic [HALF_W-1:0]   PAL_LO_RESET  = 48'd187228901376128;
    localparam logic [HALF_W-1:0]   PAL_HI_RESET  = 48'd281328771519957;
    localparam logic [WEIGHT_W-1:0] W_RED_RESET   = 4'd2;
    localparam logic [WEIGHT_W-1:0] W_GREEN_RESET = 4'd4;
    localparam logic [WEIGHT_W-1:0] W_BLUE_RESET  = 4'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PAL_LO  = 3'd0,
        REG_PAL_HI  = 3'd1,
        REG_W_RED   = 3'd2,
        REG_W_GREEN = 3'd3,
        REG_W_BLUE  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [SLOT_W-1:0] idx;
        logic [DIST_W-1:0] cost;
    } t_cand;

    function automatic logic [SQ_W-1:0] sq_diff(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
        logic [LEVEL_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return {2'b00, d} * {2'b00, d};
    endfunction

    function automatic logic [DIST_W-1:0] wdist(
        logic [COLOUR_W-1:0] c,
        logic [COLOUR_W-1:0] p,
        logic [WEIGHT_W-1:0] wr,
        logic [WEIGHT_W-1:0] wg,
        logic [WEIGHT_W-1:0] wb
    );
        logic [PROD_W-1:0] pr, pg, pb;
        logic [SUM_W-1:0]  sum;
        pr  = {4'b0000, sq_diff(c[5:4], p[5:4])} * {4'b0000, wr};
        pg  = {4'b0000, sq_diff(c[3:2], p[3:2])} * {4'b0000, wg};
        pb  = {4'b0000, sq_diff(c[1:0], p[1:0])} * {4'b0000, wb};
        sum = {2'b00, pr} + {2'b00, pg} + {2'b00, pb};
        return sum[DIST_W-1:0];
    endfunction

    // lower index (a) keeps a tie
    function automatic t_cand pick(t_cand a, t_cand b);
        return (b.cost < a.cost) ? b : a;
    endfunction

endpackage

@@ hw/rtl/nearest_palette_colour.sv @@
// Top level of the nearest palette colour quantiser
//
// Maps a 2-2-2 RGB colour to the index of the nearest of PALETTE_SLOTS palette
// entries, nearness being weight_red*dr^2 + weight_green*dg^2 + weight_blue*db^2
// over 2-bit levels; the lowest index wins a tie.
// Input stream: s_axis_*, colour_in in tdata[5:0]. Output stream: m_axis_*,
// best_slot in tdata[3:0]. Both channels transfer when tvalid and tready are high.
// Configuration: write i_cfg_wdata to register i_cfg_index while i_cfg_we is high
// (0/1 palette halves, 2..4 weights); indexes above 4 are ignored. Write only when
// no transfer is in flight.
// Pipeline: 3 register stages (distances, then two levels of compare-select in
// each of the next two stages) that all advance together. Throughput: one colour
// per cycle while the result is taken or the output slot is empty.
// Stall: when the result is not taken, the whole pipeline holds and s_axis_tready
// drops; nothing is lost or repeated.
// Reset: synchronous, active low; empties the pipeline and loads the default
// palette (16 VGA colours cut to 2-2-2) and weights 2, 4, 3.
module nearest_palette_colour #(
    parameter int PALETTE_SLOTS = npc_pkg::MAX_SLOTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [npc_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // [5:0] colour_in
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [npc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [3:0] best_slot
    input  logic                           i_cfg_we,
    input  logic [npc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [npc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import npc_pkg::*;

    // configuration registers
    logic [HALF_W-1:0]   r_pal_lo, r_pal_hi;
    logic [WEIGHT_W-1:0] r_w_red, r_w_green, r_w_blue;

    // pipeline
    logic                r_v1, r_v2, r_v3;
    logic [DIST_W-1:0]   r_dist1 [MAX_SLOTS];
    t_cand               r_cand2 [4];
    logic [SLOT_W-1:0]   r_best;

    logic                en;
    logic [DIST_W-1:0]   n_dist1 [MAX_SLOTS];
    t_cand               lvl_a   [8];
    t_cand               n_cand2 [4];
    t_cand               lvl_c   [2];
    t_cand               n_best;

    // every stage moves when the output slot is free or being emptied
    assign en            = !r_v3 || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_TDATA_W-SLOT_W){1'b0}}, r_best};

    // stage 1: one weighted distance per slot; absent slots never win
    for (genvar s = 0; s < MAX_SLOTS; s++) begin : g_dist
        logic [COLOUR_W-1:0] pal;
        if (s < HALF_SLOTS) begin : g_lo
            assign pal = r_pal_lo[COLOUR_W*s +: COLOUR_W];
        end else begin : g_hi
            assign pal = r_pal_hi[COLOUR_W*(s-HALF_SLOTS) +: COLOUR_W];
        end
        if (s < PALETTE_SLOTS) begin : g_real
            assign n_dist1[s] = wdist(s_axis_tdata[COLOUR_W-1:0], pal,
                                      r_w_red, r_w_green, r_w_blue);
        end else begin : g_pad
            assign n_dist1[s] = DIST_MAX;
        end
    end

    // stage 2: 16 -> 8 -> 4
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            lvl_a[i] = pick('{idx: SLOT_W'(2*i),   cost: r_dist1[2*i]},
                            '{idx: SLOT_W'(2*i+1), cost: r_dist1[2*i+1]});
        end
        for (int i = 0; i < 4; i++) begin
            n_cand2[i] = pick(lvl_a[2*i], lvl_a[2*i+1]);
        end
    end

    // stage 3: 4 -> 2 -> 1
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            lvl_c[i] = pick(r_cand2[2*i], r_cand2[2*i+1]);
        end
        n_best = pick(lvl_c[0], lvl_c[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pal_lo  <= PAL_LO_RESET;
            r_pal_hi  <= PAL_HI_RESET;
            r_w_red   <= W_RED_RESET;
            r_w_green <= W_GREEN_RESET;
            r_w_blue  <= W_BLUE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PAL_LO:  r_pal_lo  <= i_cfg_wdata[HALF_W-1:0];
                REG_PAL_HI:  r_pal_hi  <= i_cfg_wdata[HALF_W-1:0];
                REG_W_RED:   r_w_red   <= i_cfg_wdata[WEIGHT_W-1:0];
                REG_W_GREEN: r_w_green <= i_cfg_wdata[WEIGHT_W-1:0];
                REG_W_BLUE:  r_w_blue  <= i_cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist1 <= n_dist1;
            r_cand2 <= n_cand2;
            r_best  <= n_best.idx;
        end
    end

endmodule

@@ hw/rtl/npc_checker.sv @@
// Port-level checks for the nearest palette colour block, bound to the top level
`include "nearest_palette_colour_assert.svh"

module npc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [npc_pkg::OUT_TDATA_W-1:0] m_axis_tdata    // [3:0] best_slot
);
    import npc_pkg::*;

    // stalled result holds still
    `NPC_ASSERT_RST(a_out_hold, i_clk, i_rst_n,
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
        "result changed while stalled")

    // an empty output slot never back-pressures the source
    `NPC_ASSERT_RST(a_ready_empty, i_clk, i_rst_n,
        (!m_axis_tvalid) |-> s_axis_tready,
        "input stalled with empty output")

    // padding above best_slot stays zero
    `NPC_ASSERT_RST(a_pad_zero, i_clk, i_rst_n,
        m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:SLOT_W] == '0),
        "nonzero padding in result")

    // reset empties the pipeline
    `NPC_ASSERT(a_reset_empty, i_clk, 1'b0,
        (!i_rst_n) |=> (!m_axis_tvalid),
        "result valid after reset")

endmodule

bind nearest_palette_colour npc_checker u_npc_checker (.*);

@@ bench/tb.sv @@
// Self-checking testbench for the nearest palette colour quantiser
module tb;
    import npc_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 8;
    localparam int SETTLE_CYCLES = 8;      // well past the three-stage latency
    localparam int LONG_HOLD     = 64;     // receiver back-pressure stretch
    localparam int PCT_LOW       = 15;
    localparam int PCT_HIGH      = 77;
    localparam int PHASE_ITEMS   = 216;
    localparam int CHUNKS        = 4;
    localparam int TIMEOUT       = 3000000;
    localparam logic [WEIGHT_W-1:0]  WEIGHT_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_W_BLUE + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

    // register state of the predictor, power-on values
    localparam logic [HALF_W-1:0] BOOT_PAL_LO = 48'd187228901376128;
    localparam logic [HALF_W-1:0] BOOT_PAL_HI = 48'd281328771519957;

    // holds the expected slot per accepted colour, and the register copy
    class nearest_slot_book;
        logic [HALF_W-1:0]   pal_lo;
        logic [HALF_W-1:0]   pal_hi;
        logic [WEIGHT_W-1:0] w_red;
        logic [WEIGHT_W-1:0] w_green;
        logic [WEIGHT_W-1:0] w_blue;
        logic [SLOT_W-1:0]   expected_slots[$];
        int                  errors;

        function new();
            pal_lo  = BOOT_PAL_LO;
            pal_hi  = BOOT_PAL_HI;
            w_red   = 4'd2;
            w_green = 4'd4;
            w_blue  = 4'd3;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PAL_LO:  pal_lo  = data[HALF_W-1:0];
                REG_PAL_HI:  pal_hi  = data[HALF_W-1:0];
                REG_W_RED:   w_red   = data[WEIGHT_W-1:0];
                REG_W_GREEN: w_green = data[WEIGHT_W-1:0];
                REG_W_BLUE:  w_blue  = data[WEIGHT_W-1:0];
                default: ;   // unmapped index, dropped
            endcase
        endfunction

        function int unsigned level_sq(logic [LEVEL_W-1:0] a, logic [LEVEL_W-1:0] b);
            int unsigned d;
            d = (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
            return d * d;
        endfunction

        function logic [SLOT_W-1:0] nearest_slot(logic [COLOUR_W-1:0] c);
            int unsigned         best_d;
            int unsigned         d;
            logic [SLOT_W-1:0]   best;
            logic [COLOUR_W-1:0] p;
            best_d = 32'hFFFF_FFFF;
            best   = '0;
            for (int s = 0; s < MAX_SLOTS; s++) begin
                p = (s < HALF_SLOTS) ? pal_lo[COLOUR_W*s +: COLOUR_W]
                                     : pal_hi[COLOUR_W*(s-HALF_SLOTS) +: COLOUR_W];
                d = w_red   * level_sq(c[5:4], p[5:4])
                  + w_green * level_sq(c[3:2], p[3:2])
                  + w_blue  * level_sq(c[1:0], p[1:0]);
                // strict compare keeps the lower slot on a tie
                if (d < best_d) begin
                    best_d = d;
                    best   = SLOT_W'(s);
                end
            end
            return best;
        endfunction

        function void note_colour(logic [COLOUR_W-1:0] c);
            expected_slots.push_back(nearest_slot(c));
        endfunction

        function void check_slot(logic [SLOT_W-1:0] got);
            logic [SLOT_W-1:0] want;
            if (expected_slots.size() == 0) begin
                $display("%0t: result with nothing pending: expected none, actual %0d",
                         $time, got);
                errors++;
            end else begin
                want = expected_slots.pop_front();
                if (got !== want) begin
                    $display("%0t: best_slot mismatch: expected %0d, actual %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [5:0] colour_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [3:0] best_slot
    logic                   i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = REG_PAL_LO;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata   = '0;

    nearest_slot_book slots = new();

    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic hold_req      = 1'b0;   // toggled to ask for a long back-pressure stretch
    logic hold_ack      = 1'b0;
    int   hold_left     = 0;

    nearest_palette_colour uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // result side: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // transfer monitor: pre-edge values, so no race with the drivers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                slots.note_colour(s_axis_tdata[COLOUR_W-1:0]);
            if (m_axis_tvalid && m_axis_tready)
                slots.check_slot(m_axis_tdata[SLOT_W-1:0]);
        end
    end

    // offer one colour, with a random gap first; returns at its transfer edge
    task automatic send_colour(input logic [COLOUR_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-COLOUR_W){1'b0}}, c};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // stop offering and let every pending result come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (slots.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        slots.write_reg(idx, data);
    endtask

    function automatic logic [CFG_DATA_W-1:0] rand_word();
        return CFG_DATA_W'({$urandom, $urandom});
    endfunction

    // weight in the low nibble, junk above it to exercise truncation
    function automatic logic [CFG_DATA_W-1:0] rand_weight_word();
        logic [CFG_DATA_W-1:0] v;
        v = rand_word();
        case ($urandom_range(0, 3))
            0:       v[WEIGHT_W-1:0] = '0;
            1:       v[WEIGHT_W-1:0] = WEIGHT_MAX;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_palette_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'({HALF_W{1'b1}});
            default: return rand_word();
        endcase
    endfunction

    task automatic random_setting();
        write_reg(REG_PAL_LO,  rand_palette_word());
        write_reg(REG_PAL_HI,  rand_palette_word());
        write_reg(REG_W_RED,   rand_weight_word());
        write_reg(REG_W_GREEN, rand_weight_word());
        write_reg(REG_W_BLUE,  rand_weight_word());
        if ($urandom_range(0, 1))
            write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      rand_word());
    endtask

    // one idling profile: a fresh register setting before every chunk
    task automatic random_phase(input int snd_pct, input int rcv_pct, input bit squeeze);
        send_idle_pct = snd_pct;
        recv_idle_pct <= rcv_pct;
        for (int k = 0; k < CHUNKS; k++) begin
            drain();
            random_setting();
            if (squeeze)
                hold_req <= ~hold_req;   // sender keeps offering through the hold
            for (int n = 0; n < PHASE_ITEMS / CHUNKS; n++)
                send_colour(COLOUR_W'($urandom));
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] pal;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: power-on palette, corners and primaries
        send_colour(6'h00);
        send_colour(6'h3F);
        send_colour(6'h15);
        send_colour(6'h2A);
        send_colour(6'h30);
        send_colour(6'h0C);
        send_colour(6'h03);
        send_colour(6'h3C);
        drain();

        // all weights zero: every distance ties, slot 0 wins
        write_reg(REG_W_RED,   '0);
        write_reg(REG_W_GREEN, '0);
        write_reg(REG_W_BLUE,  '0);
        send_colour(6'h3F);
        send_colour(6'h21);
        drain();

        // maximum weights with junk above the nibble; twin nearest entries
        // in both halves, lower one must win
        write_reg(REG_W_RED,   '1);
        write_reg(REG_W_GREEN, '1);
        write_reg(REG_W_BLUE,  '1);
        pal = '0;
        pal[HALF_W-1:0] = {HALF_SLOTS{6'h3F}};
        pal[COLOUR_W*3 +: COLOUR_W] = 6'h15;
        write_reg(REG_PAL_LO, pal);
        write_reg(REG_PAL_HI, pal);
        send_colour(6'h15);
        send_colour(6'h3F);
        send_colour(6'h00);
        drain();

        // unmapped register indexes must change nothing
        for (int i = REG_FIRST_UNUSED; i <= REG_LAST_UNUSED; i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_colour(6'h2A);
        drain();

        // whole palette one colour, mixed weights
        write_reg(REG_PAL_LO, '0);
        write_reg(REG_PAL_HI, '0);
        write_reg(REG_W_GREEN, {{(CFG_DATA_W-WEIGHT_W){1'b0}}, 4'd7});
        send_colour(6'h3F);

        random_phase(PCT_LOW,  PCT_HIGH, 1'b0);
        random_phase(PCT_HIGH, PCT_LOW,  1'b0);
        random_phase(0,        0,        1'b1);

        drain();
        if (slots.errors == 0 && slots.pending() == 0)
            $display("nearest_palette_colour regression: pass");
        else
            $display("nearest_palette_colour regression: fail");
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("nearest_palette_colour regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/npc_pkg.sv
hw/rtl/nearest_palette_colour.sv
hw/rtl/npc_checker.sv
bench/tb.sv
